// ----- hw/rtl/pfg_pkg.sv -----
`timescale 1ns / 1ps

package pfg_pkg;

  localparam int MAX_SIDE_DEF = 32;

  localparam int SAMPLE_W    = 32;
  localparam int COORD_W     = 5;
  localparam int SIDE_W      = 6;
  localparam int AXIS_W      = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIDE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE     = 2'd2;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd3;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_GRAD = 1'b1;

  localparam logic [SIDE_W-1:0]     GRID_SIDE_RST = 6'd32;
  localparam logic [AXIS_W-1:0]     AXIS_RST      = AXIS_X;
  localparam logic [CFG_DATA_W-1:0] SCALE_RST     = 32'h0001_0000;
  localparam logic [SIDE_W-1:0]     SIDE_MIN      = 6'd2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SIDE_W-1:0]  side_t;
  typedef logic signed [2:0]  step_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    func;
    coord_t  pos_x;
    coord_t  pos_y;
    coord_t  pos_z;
    sample_t sample;
  } in_word_t;

  typedef struct packed {
    sample_t gradient;
  } out_word_t;

  typedef struct packed {
    sample_t fm2;
    sample_t fm1;
    sample_t fp1;
    sample_t fp2;
  } stencil_t;

  function automatic side_t eff_side(side_t g, side_t cap);
    side_t s;
    s = g;
    if (s < SIDE_MIN) s = SIDE_MIN;
    if (s > cap) s = cap;
    return s;
  endfunction

  // restoring remainder, one coordinate bit per step
  function automatic coord_t mod_side(coord_t c, side_t s);
    side_t r;
    r = '0;
    for (int i = COORD_W - 1; i >= 0; i--) begin
      r = {r[SIDE_W-2:0], c[i]};
      if (r >= s) r = r - s;
    end
    return r[COORD_W-1:0];
  endfunction

  // read slot to neighbour offset: -2, -1, +1, +2
  function automatic step_t step_of(logic [1:0] k);
    step_t st;
    case (k)
      2'd0: st = -3'sd2;
      2'd1: st = -3'sd1;
      2'd2: st = 3'sd1;
      default: st = 3'sd2;
    endcase
    return st;
  endfunction

endpackage

// ----- hw/rtl/pfg_stream_if.sv -----
`timescale 1ns / 1ps

interface pfg_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hw/rtl/periodic_fourth_order_gradient_unit.sv -----
`timescale 1ns / 1ps
// Fourth-order periodic gradient on a cubic grid of Q16.16 samples.
// item channel: one word per request; func selects a load of sample at
// (pos_x, pos_y, pos_z) or a gradient request at that point. Coordinates
// are reduced modulo the active side. result channel: one gradient word
// per gradient request, none per load.
// Configuration: write port (cfg_we, cfg_index, cfg_data) for grid_side,
// axis and scale; write only while no request is in flight.
// A load writes its sample in the LOAD state and returns to idle. A gradient
// request issues four neighbour reads to the single-port sample memory, takes
// the last word in the next cycle, then runs an arithmetic unit (difference,
// two 36x16 products, rounding, division by six at 8 bits a cycle,
// saturation); the result word becomes valid in the same cycle as the unit
// returns to idle and can take the next item.
// Requests are handled one at a time. The result register frees the input
// side: a new item is taken while a result waits; a finished gradient waits
// in the unit until the result register is free, so a stalled receiver
// holds the block after at most one further gradient request.
// Reset clears control state and restores the registers to side 32, axis x,
// scale 1.0; the sample memory is not cleared and must be loaded before use.
module periodic_fourth_order_gradient_unit
  import pfg_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  pfg_stream_if.sink             item,
  pfg_stream_if.source           result
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int AW = $clog2(DEPTH);
  localparam side_t SIDE_CAP = side_t'((MAX_SIDE < 32) ? MAX_SIDE : 32);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_LAST = 3'd3;
  localparam logic [2:0] ST_CALC = 3'd4;

  logic [SIDE_W-1:0]     grid_side;
  logic [AXIS_W-1:0]     axis;
  logic [CFG_DATA_W-1:0] scale;

  logic [2:0]  state;
  coord_t      px;
  coord_t      py;
  coord_t      pz;
  sample_t     smp;
  logic [1:0]  k;
  logic [1:0]  rd_k;
  logic        rd_v;
  sample_t     fm2;
  sample_t     fm1;
  sample_t     fp1;
  logic        out_valid;
  out_word_t   out_word;

  side_t       side;
  in_word_t    iw;
  logic        accept;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;
  step_t       step;
  stencil_t    taps;
  logic        calc_start;
  logic        calc_done;
  sample_t     calc_result;
  logic        push;

  assign side = eff_side(grid_side, SIDE_CAP);
  assign iw = item.data;
  assign accept = item.valid && item.ready;
  assign item.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= GRID_SIDE_RST;
      axis <= AXIS_RST;
      scale <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_SIDE: grid_side <= cfg_data[SIDE_W-1:0];
        REG_AXIS:      axis <= cfg_data[AXIS_W-1:0];
        REG_SCALE:     scale <= cfg_data;
        default: ;
      endcase
    end
  end

  assign push = (state == ST_CALC) && calc_done && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k <= '0;
      rd_v <= 1'b0;
    end else begin
      rd_v <= (state == ST_READ);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            k <= '0;
            state <= (iw.func == FUNC_LOAD) ? ST_LOAD : ST_READ;
          end
        end
        ST_LOAD: state <= ST_IDLE;
        ST_READ: begin
          k <= k + 2'd1;
          if (k == 2'd3) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: state <= ST_CALC;
        ST_CALC: begin
          if (push) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_k <= k;
    if (accept) begin
      px <= mod_side(iw.pos_x, side);
      py <= mod_side(iw.pos_y, side);
      pz <= mod_side(iw.pos_z, side);
      smp <= iw.sample;
    end
    if (rd_v) begin
      case (rd_k)
        2'd0: fm2 <= ram_rdata;
        2'd1: fm1 <= ram_rdata;
        2'd2: fp1 <= ram_rdata;
        default: ;
      endcase
    end
  end

  assign step = (state == ST_LOAD) ? 3'sd0 : step_of(k);
  assign ram_we = (state == ST_LOAD);

  pfg_addr #(.MAX_SIDE(MAX_SIDE)) u_addr (
    .x    (px),
    .y    (py),
    .z    (pz),
    .side (side),
    .axis (axis),
    .step (step),
    .addr (ram_addr)
  );

  pfg_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (smp),
    .rdata (ram_rdata)
  );

  // last neighbour comes straight from the memory
  assign taps = '{fm2: fm2, fm1: fm1, fp1: fp1, fp2: ram_rdata};
  assign calc_start = (state == ST_LAST);

  pfg_calc u_calc (
    .clk    (clk),
    .rst    (rst),
    .start  (calc_start),
    .taps   (taps),
    .scale  (scale),
    .done   (calc_done),
    .result (calc_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_word.gradient <= calc_result;
    end
  end

  assign result.valid = out_valid;
  assign result.data = out_word;

endmodule

// ----- hw/rtl/pfg_ram.sv -----
`timescale 1ns / 1ps

module pfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/pfg_addr.sv -----
`timescale 1ns / 1ps

module pfg_addr
  import pfg_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE,
  localparam int AW = $clog2(DEPTH)
) (
  input  coord_t            x,
  input  coord_t            y,
  input  coord_t            z,
  input  side_t             side,
  input  logic [AXIS_W-1:0] axis,
  input  step_t             step,
  output logic [AW-1:0]     addr
);

  localparam logic [AW-1:0] ROW   = AW'(MAX_SIDE);
  localparam logic [AW-1:0] PLANE = AW'(MAX_SIDE * MAX_SIDE);

  coord_t cx;
  coord_t cy;
  coord_t cz;

  function automatic coord_t wrap(coord_t c, step_t d, side_t s);
    logic signed [SIDE_W:0] t;
    logic signed [SIDE_W:0] sv;
    sv = $signed({1'b0, s});
    t = $signed({2'b00, c}) + $signed({{(SIDE_W - 2){d[2]}}, d});
    if (t < 0) begin
      t = t + sv;
    end else if (t >= sv) begin
      t = t - sv;
    end
    return t[COORD_W-1:0];
  endfunction

  always_comb begin
    cx = x;
    cy = y;
    cz = z;
    case (axis)
      AXIS_Y: cy = wrap(y, step, side);
      AXIS_Z: cz = wrap(z, step, side);
      default: cx = wrap(x, step, side);
    endcase
  end

  assign addr = AW'(cx) * PLANE + AW'(cy) * ROW + AW'(cz);

endmodule

// ----- hw/rtl/pfg_calc.sv -----
`timescale 1ns / 1ps

module pfg_calc
  import pfg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  stencil_t              taps,
  input  logic [CFG_DATA_W-1:0] scale,
  output logic                  done,
  output sample_t               result
);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_DIFF  = 3'd1;
  localparam logic [2:0] C_MUL   = 3'd2;
  localparam logic [2:0] C_ROUND = 3'd3;
  localparam logic [2:0] C_DIV   = 3'd4;
  localparam logic [2:0] C_SAT   = 3'd5;
  localparam logic [2:0] C_OUT   = 3'd6;

  localparam int DIV_BITS  = 8;
  localparam int SH_W      = 40;
  localparam logic [2:0] DIV_LAST = 3'd4;
  localparam logic [52:0] ROUND_BIAS = 53'd196608;
  localparam logic [52:0] U_LIMIT    = 53'h5_FFFF_FFFF;
  localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAG    = 32'h8000_0000;

  logic [2:0]          st;
  logic signed [32:0]  d1;
  logic signed [32:0]  d2;
  logic                neg;
  logic [35:0]         m;
  logic [51:0]         pa;
  logic [51:0]         pb;
  logic [SH_W-1:0]     sh;
  logic [1:0]          rem;
  logic [2:0]          cnt;
  sample_t             res;

  logic signed [36:0]  n_c;
  logic [52:0]         u_c;
  logic [52:0]         uc_c;
  logic [1:0]          rem_c;
  logic [2:0]          t_c;
  logic [DIV_BITS-1:0] qbits;
  logic [31:0]         q_c;

  assign n_c = ({{4{d1[32]}}, d1} <<< 3) - {{4{d2[32]}}, d2};
  assign u_c = 53'(pa) + ((53'(pb) + ROUND_BIAS) >> 16);
  assign uc_c = (u_c > U_LIMIT) ? U_LIMIT : u_c;
  assign q_c = sh[31:0];

  // radix-2 long division by three
  always_comb begin
    rem_c = rem;
    t_c = '0;
    qbits = '0;
    for (int j = 0; j < DIV_BITS; j++) begin
      t_c = {rem_c, sh[SH_W-1-j]};
      qbits[DIV_BITS-1-j] = (t_c >= 3'd3);
      rem_c = (t_c >= 3'd3) ? 2'(t_c - 3'd3) : t_c[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= C_IDLE;
    end else begin
      case (st)
        C_DIFF:  st <= C_MUL;
        C_MUL:   st <= C_ROUND;
        C_ROUND: st <= C_DIV;
        C_DIV:   st <= (cnt == DIV_LAST) ? C_SAT : C_DIV;
        C_SAT:   st <= C_OUT;
        default: st <= st;
      endcase
      if (start) begin
        st <= C_DIFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d1 <= 33'(taps.fm1) - 33'(taps.fp1);
      d2 <= 33'(taps.fm2) - 33'(taps.fp2);
    end
    case (st)
      C_DIFF: begin
        neg <= n_c[36];
        m <= n_c[36] ? 36'(-n_c) : n_c[35:0];
      end
      C_MUL: begin
        pa <= 52'(m) * 52'(scale[31:16]);
        pb <= 52'(m) * 52'(scale[15:0]);
      end
      C_ROUND: begin
        sh <= {{(SH_W - 34){1'b0}}, uc_c[34:1]};
        rem <= '0;
        cnt <= '0;
      end
      C_DIV: begin
        sh <= {sh[SH_W-DIV_BITS-1:0], qbits};
        rem <= rem_c;
        cnt <= cnt + 3'd1;
      end
      C_SAT: begin
        if (neg) begin
          res <= (q_c > POS_MAX) ? POS_MAX : q_c;
        end else begin
          res <= (q_c > NEG_MAG) ? NEG_MAG : 32'(32'd0 - q_c);
        end
      end
      default: ;
    endcase
  end

  assign done = (st == C_OUT);
  assign result = res;

endmodule
